// ===== design/trigger_line_rate_counters_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trigger rate scaler checker
// Clock clk and active-low reset rst_n are taken from the calling scope.
// ----------------------------------------------------------------------------
`ifndef TRIGGER_LINE_RATE_COUNTERS_TOP_MACROS_SVH
`define TRIGGER_LINE_RATE_COUNTERS_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TRLC_ASSERT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("trlc assertion failed");

// Next-cycle implication, disabled during reset
`define TRLC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("trlc assertion failed");

// Same-cycle implication that also holds while reset is applied
`define TRLC_ASSERT_RST(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) (ant) |-> (cons)) \
        else $error("trlc assertion failed");

`endif

// ===== design/trlc_pkg.sv =====
// ----------------------------------------------------------------------------
// trlc_pkg
// Shared constants, types and helpers of the trigger rate scaler.
// ----------------------------------------------------------------------------
package trlc_pkg;

    // Sizing
    localparam int MAX_LINES   = 64;
    localparam int NUM_GROUPS  = 4;
    localparam int COUNT_WIDTH = 32;
    localparam int GROUP_SLOTS = 4;

    // Field widths
    localparam int DEC_W   = 64;
    localparam int IDX_W   = 7;
    localparam int OUT_W   = 32;
    localparam int ACT_W   = 7;
    localparam int MASK_W  = 64;

    // Read index map
    localparam int GROUP_BASE      = 64;
    localparam int INCLUSIVE_INDEX = 68;

    // Read mux banking: line counters are grouped in banks of eight
    localparam int BANK_BITS  = 3;
    localparam int BANK_SIZE  = 1 << BANK_BITS;
    localparam int LINE_BANKS = (MAX_LINES + BANK_SIZE - 1) / BANK_SIZE;
    localparam int SEL_BITS   = (LINE_BANKS > 1) ? $clog2(LINE_BANKS) : 1;
    localparam int NUM_SEL    = 1 << SEL_BITS;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LINES = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_MASK_A = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_MASK_B = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_MASK_C = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_MASK_D = 3'd4;

    localparam logic [ACT_W-1:0] ACTIVE_LINES_RESET = 7'd64;

    // Item kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    typedef struct packed {
        logic [ACT_W-1:0]                   active_lines;
        logic [GROUP_SLOTS-1:0][MASK_W-1:0] group_masks;
    } cfg_t;

    // Low result bits of a counter, zero-extended when the counter is narrow
    function automatic logic [OUT_W-1:0] to_out(input cnt_t c);
        logic [63:0] wide;
        wide = 64'(c);
        return wide[OUT_W-1:0];
    endfunction

endpackage

// ===== design/trlc_if.sv =====
// ----------------------------------------------------------------------------
// trlc_in_if / trlc_out_if
// Valid/ready channels for input items and read results.
// ----------------------------------------------------------------------------
interface trlc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [trlc_pkg::DEC_W-1:0]  line_decisions;
    logic [trlc_pkg::IDX_W-1:0]  counter_index;

    modport source (output valid, kind, line_decisions, counter_index, input ready);
    modport sink   (input valid, kind, line_decisions, counter_index, output ready);
endinterface

interface trlc_out_if;
    logic                        valid;
    logic                        ready;
    logic [trlc_pkg::OUT_W-1:0]  count_value;
    logic                        bad_index;

    modport source (output valid, count_value, bad_index, input ready);
    modport sink   (input valid, count_value, bad_index, output ready);
endinterface

// ===== design/trlc_cfg.sv =====
// ----------------------------------------------------------------------------
// trlc_cfg
// APB-style register file: active line count and four group masks.
// ----------------------------------------------------------------------------
module trlc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trlc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [trlc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [trlc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output trlc_pkg::cfg_t                    cfg
);

    trlc_pkg::cfg_t                  cfg_reg;
    trlc_pkg::cfg_t                  cfg_next;
    logic [trlc_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[trlc_pkg::REG_LSB +: trlc_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                trlc_pkg::REG_ACTIVE_LINES:
                    cfg_next.active_lines = pwdata[trlc_pkg::ACT_W-1:0];
                trlc_pkg::REG_GROUP_MASK_A: cfg_next.group_masks[0] = pwdata;
                trlc_pkg::REG_GROUP_MASK_B: cfg_next.group_masks[1] = pwdata;
                trlc_pkg::REG_GROUP_MASK_C: cfg_next.group_masks[2] = pwdata;
                trlc_pkg::REG_GROUP_MASK_D: cfg_next.group_masks[3] = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_lines <= trlc_pkg::ACTIVE_LINES_RESET;
            cfg_reg.group_masks  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            trlc_pkg::REG_ACTIVE_LINES:
                prdata = trlc_pkg::CFG_DATA_W'(cfg_reg.active_lines);
            trlc_pkg::REG_GROUP_MASK_A: prdata = cfg_reg.group_masks[0];
            trlc_pkg::REG_GROUP_MASK_B: prdata = cfg_reg.group_masks[1];
            trlc_pkg::REG_GROUP_MASK_C: prdata = cfg_reg.group_masks[2];
            trlc_pkg::REG_GROUP_MASK_D: prdata = cfg_reg.group_masks[3];
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/trlc_lane.sv =====
// ----------------------------------------------------------------------------
// trlc_lane
// One wrapping event counter; the block holds one lane per counter.
// ----------------------------------------------------------------------------
module trlc_lane (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           inc,
    output trlc_pkg::cnt_t count
);

    trlc_pkg::cnt_t cnt_reg;
    trlc_pkg::cnt_t cnt_next;

    // Increment wraps at the counter width
    assign cnt_next = inc ? (cnt_reg + trlc_pkg::cnt_t'(1)) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign count = cnt_reg;

endmodule

// ===== design/trlc_merge.sv =====
// ----------------------------------------------------------------------------
// trlc_merge
// Two-stage read mux over all lane counters, with result output register.
// ----------------------------------------------------------------------------
module trlc_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_valid,
    input  logic [trlc_pkg::IDX_W-1:0]    rd_index,
    input  trlc_pkg::cnt_t                line_cnt [trlc_pkg::MAX_LINES],
    input  trlc_pkg::cnt_t                grp_cnt  [trlc_pkg::NUM_GROUPS],
    input  trlc_pkg::cnt_t                incl_cnt,
    output logic                          rd_ready,
    trlc_out_if.source                    res_out
);

    // Stage 1: per-bank selection, snapshot of counters at accept
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    trlc_pkg::cnt_t                bank_word_reg  [trlc_pkg::NUM_SEL];
    trlc_pkg::cnt_t                bank_word_next [trlc_pkg::NUM_SEL];
    trlc_pkg::cnt_t                aux_word_reg;
    trlc_pkg::cnt_t                aux_word_next;
    logic [trlc_pkg::SEL_BITS-1:0] sel_reg;
    logic                          is_line_reg;
    logic                          is_line_next;
    logic                          bad_reg;
    logic                          bad_next;
    logic                          grp_hit;
    logic                          incl_hit;

    // Stage 2: output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [trlc_pkg::OUT_W-1:0]    value_reg;
    logic [trlc_pkg::OUT_W-1:0]    value_next;
    logic                          bad_out_reg;

    logic                          out_load;
    logic                          s1_load;

    // Flow control
    assign out_load = s1_valid_reg && (!out_valid_reg || res_out.ready);
    assign rd_ready = !s1_valid_reg || out_load;
    assign s1_load  = rd_valid;

    assign s1_valid_next  = s1_load ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (res_out.ready ? 1'b0 : out_valid_reg);

    // Bank muxes over line lanes
    always_comb
    begin
        for (int b = 0; b < trlc_pkg::NUM_SEL; b++)
        begin
            bank_word_next[b] = '0;
            for (int k = 0; k < trlc_pkg::BANK_SIZE; k++)
            begin
                if ((b * trlc_pkg::BANK_SIZE + k) < trlc_pkg::MAX_LINES)
                begin
                    if (rd_index[trlc_pkg::BANK_BITS-1:0] == trlc_pkg::BANK_BITS'(k))
                    begin
                        bank_word_next[b] = line_cnt[b * trlc_pkg::BANK_SIZE + k];
                    end
                end
            end
        end
    end

    // Group and inclusive counters
    always_comb
    begin
        aux_word_next = '0;
        grp_hit       = 1'b0;
        for (int g = 0; g < trlc_pkg::NUM_GROUPS; g++)
        begin
            if (rd_index == trlc_pkg::IDX_W'(trlc_pkg::GROUP_BASE + g))
            begin
                aux_word_next = grp_cnt[g];
                grp_hit       = 1'b1;
            end
        end
        incl_hit = (rd_index == trlc_pkg::IDX_W'(trlc_pkg::INCLUSIVE_INDEX));
        if (incl_hit)
        begin
            aux_word_next = incl_cnt;
        end
    end

    assign is_line_next = (rd_index < trlc_pkg::IDX_W'(trlc_pkg::MAX_LINES));
    assign bad_next     = !(is_line_next || grp_hit || incl_hit);

    // Final selection
    always_comb
    begin
        if (bad_reg)
        begin
            value_next = '0;
        end
        else if (is_line_reg)
        begin
            value_next = trlc_pkg::to_out(bank_word_reg[sel_reg]);
        end
        else
        begin
            value_next = trlc_pkg::to_out(aux_word_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            bank_word_reg <= bank_word_next;
            aux_word_reg  <= aux_word_next;
            sel_reg       <= rd_index[trlc_pkg::BANK_BITS +: trlc_pkg::SEL_BITS];
            is_line_reg   <= is_line_next;
            bad_reg       <= bad_next;
        end
        if (out_load)
        begin
            value_reg   <= value_next;
            bad_out_reg <= bad_reg;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.count_value = value_reg;
    assign res_out.bad_index   = bad_out_reg;

endmodule

// ===== design/trigger_line_rate_counters_top.sv =====
// ----------------------------------------------------------------------------
// trigger_line_rate_counters_top
// Trigger rate scaler: per-line, per-group and inclusive event counters.
// ----------------------------------------------------------------------------
// Usage:
//   ev_in carries one item per beat. An event item (kind 0) carries one fired
//   bit per trigger line; fired lines below active_lines bump their counters,
//   the inclusive total and every group whose mask overlaps them. A read item
//   (kind 1) selects one counter by counter_index and yields one beat on
//   res_out with its value, or bad_index set and value zero.
//   Throughput: one item per cycle, events and reads alike, while ev_in.ready
//   is high. Every counter has its own incrementer, so all counters of an
//   event update in parallel at the accepting edge.
//   Read path: an accepted read is registered in the bank mux stage, then
//   the final select loads the output register that drives res_out. The
//   value is the count after all events accepted before the read.
//   Stall: up to two reads are held while res_out.ready is low; ev_in.ready
//   falls once both places are full and rises as soon as one drains.
//   Reset: all counters clear at once, active_lines returns to 64, masks 0.
//   Config: APB registers at 8*i (active_lines, group_mask_a..d). The user
//   writes them while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module trigger_line_rate_counters_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trlc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [trlc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [trlc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    trlc_in_if.sink                           ev_in,
    trlc_out_if.source                        res_out
);

    trlc_pkg::cfg_t                    cfg;
    logic                              accept;
    logic                              ev_fire;
    logic                              rd_valid;
    logic                              rd_ready;
    logic [trlc_pkg::MAX_LINES-1:0]    act_mask;
    logic [trlc_pkg::MAX_LINES-1:0]    fired;
    logic                              any_fired;
    logic [trlc_pkg::ACT_W-1:0]        act_n;
    logic [trlc_pkg::NUM_GROUPS-1:0]   grp_inc;
    trlc_pkg::cnt_t                    line_cnt [trlc_pkg::MAX_LINES];
    trlc_pkg::cnt_t                    grp_cnt  [trlc_pkg::NUM_GROUPS];
    trlc_pkg::cnt_t                    incl_cnt;

    // Registers
    trlc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input handshake
    assign ev_in.ready = rd_ready;
    assign accept      = ev_in.valid && ev_in.ready;
    assign ev_fire     = accept && (ev_in.kind == trlc_pkg::KIND_EVENT);
    assign rd_valid    = accept && (ev_in.kind == trlc_pkg::KIND_READ);

    // Active line mask, active_lines clamped to the line count
    always_comb
    begin
        if (cfg.active_lines > trlc_pkg::ACT_W'(trlc_pkg::MAX_LINES))
        begin
            act_n = trlc_pkg::ACT_W'(trlc_pkg::MAX_LINES);
        end
        else
        begin
            act_n = cfg.active_lines;
        end
        for (int i = 0; i < trlc_pkg::MAX_LINES; i++)
        begin
            act_mask[i] = (trlc_pkg::ACT_W'(i) < act_n);
        end
    end

    assign fired     = ev_in.line_decisions[trlc_pkg::MAX_LINES-1:0] & act_mask
                       & {trlc_pkg::MAX_LINES{ev_fire}};
    assign any_fired = |fired;

    // Group overlap
    always_comb
    begin
        for (int g = 0; g < trlc_pkg::NUM_GROUPS; g++)
        begin
            grp_inc[g] = |(fired & cfg.group_masks[g][trlc_pkg::MAX_LINES-1:0]);
        end
    end

    // Counter lanes
    for (genvar i = 0; i < trlc_pkg::MAX_LINES; i++)
    begin : g_line
        trlc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .inc   (fired[i]),
            .count (line_cnt[i])
        );
    end

    for (genvar g = 0; g < trlc_pkg::NUM_GROUPS; g++)
    begin : g_group
        trlc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .inc   (grp_inc[g]),
            .count (grp_cnt[g])
        );
    end

    trlc_lane u_incl (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (any_fired),
        .count (incl_cnt)
    );

    // Read merge and result register
    trlc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_index (ev_in.counter_index),
        .line_cnt (line_cnt),
        .grp_cnt  (grp_cnt),
        .incl_cnt (incl_cnt),
        .rd_ready (rd_ready),
        .res_out  (res_out)
    );

endmodule

// ===== design/trlc_checker.sv =====
// ----------------------------------------------------------------------------
// trlc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "trigger_line_rate_counters_top_macros.svh"

module trlc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [trlc_pkg::OUT_W-1:0]    out_value,
    input logic                          out_bad
);

    // A stalled result beat stays up
    `TRLC_ASSERT_NEXT(a_valid_holds, out_valid && !out_ready, out_valid)

    // A stalled result beat keeps its payload
    `TRLC_ASSERT_NEXT(a_value_holds, out_valid && !out_ready, $stable(out_value) && $stable(out_bad))

    // A bad index reads as zero
    `TRLC_ASSERT(a_bad_is_zero, out_valid && out_bad, out_value == '0)

    // Nothing is offered while reset is applied
    `TRLC_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind trigger_line_rate_counters_top trlc_checker u_trlc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_value (res_out.count_value),
    .out_bad   (res_out.bad_index)
);
